/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge out of reset.
`define AST_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/gptd_pkg.sv */
// ----------------------------------------------------------------------------
// gptd_pkg
// Types, constants and helpers for the group priority task dispatcher.
// ----------------------------------------------------------------------------
package gptd_pkg;

  localparam int SLOTS        = 16;
  localparam int GROUPS       = 8;
  localparam int HANDLE_BITS  = 16;
  localparam int GROUP_BITS   = 3;
  localparam int PEND_BITS    = 8;
  localparam int NUM_PRIO     = 8;
  localparam int PRIO_BITS    = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);

  // request command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_DONE = 1'b1;

  // cell operation codes
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD = 2'd0;
  localparam cell_op_t CELL_TAKE = 2'd1;
  localparam cell_op_t CELL_LOAD = 2'd2;

  typedef struct packed {
    logic                   valid;
    logic [GROUP_BITS-1:0]  grp;
    logic [HANDLE_BITS-1:0] hdl;
  } slot_t;

  typedef struct packed {
    logic                   cmd;
    logic [GROUP_BITS-1:0]  group_id;
    logic [HANDLE_BITS-1:0] task_handle;
  } req_t;

  typedef struct packed {
    logic                   grant_valid;
    logic [HANDLE_BITS-1:0] grant_handle;
    logic [GROUP_BITS-1:0]  grant_group;
    logic                   add_dropped;
    logic [PEND_BITS-1:0]   pending_groups;
    logic                   now_busy;
  } res_t;

  typedef struct packed {
    logic                   found;
    logic [IDX_W-1:0]       idx;
    logic [GROUP_BITS-1:0]  grp;
    logic [HANDLE_BITS-1:0] hdl;
  } best_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  function automatic logic [PEND_BITS-1:0] group_onehot(input logic [GROUP_BITS-1:0] g);
    group_onehot = PEND_BITS'(1) << g;
  endfunction

  function automatic logic [GROUP_BITS-1:0] sat_group(input logic [GROUP_BITS-1:0] g);
    sat_group = (32'(g) >= GROUPS) ? GROUP_BITS'(GROUPS - 1) : g;
  endfunction

endpackage

/* hw/rtl/gptd_cell.sv */
// ----------------------------------------------------------------------------
// gptd_cell
// One storage cell of the slot chain: holds, takes its neighbor, or loads.
// ----------------------------------------------------------------------------
module gptd_cell
  import gptd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_op_t             op,
  input  slot_t                nb,
  input  slot_t                ld,
  input  logic                 drop,
  output slot_t                q,
  output logic [PEND_BITS-1:0] pend
);

  slot_t slot_r;
  slot_t slot_nxt;

  always_comb begin
    case (op)
      CELL_TAKE: slot_nxt = nb;
      CELL_LOAD: slot_nxt = ld;
      default:   slot_nxt = slot_r;
    endcase
  end

  // only the valid bit is reset; group and handle are read under valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
    slot_r.grp <= slot_nxt.grp;
    slot_r.hdl <= slot_nxt.hdl;
  end

  assign q    = slot_r;
  // group contribution, masked when this entry is leaving
  assign pend = (slot_r.valid && !drop) ? group_onehot(slot_r.grp) : '0;

endmodule

/* hw/rtl/gptd_scan.sv */
// ----------------------------------------------------------------------------
// gptd_scan
// Best-entry tracker at the head of the chain, one entry per cycle while ctl.step is set.
// ----------------------------------------------------------------------------
module gptd_scan
  import gptd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  scan_ctl_t                   ctl,
  input  slot_t                       head,
  input  logic signed [PRIO_BITS-1:0] head_prio,
  output best_t                       best,
  output logic                        last
);

  best_t                       best_r;
  logic signed [PRIO_BITS-1:0] bprio_r;
  logic [IDX_W-1:0]            step_r;
  logic                        take;

  // strict compare: entries arrive oldest first, so ties keep the older one
  assign take = head.valid && (!best_r.found || (head_prio > bprio_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r.found <= 1'b0;
      step_r       <= '0;
    end else if (ctl.clear) begin
      best_r.found <= 1'b0;
      step_r       <= '0;
    end else if (ctl.step) begin
      step_r <= IDX_W'(step_r + 1'b1);
      if (take) begin
        best_r.found <= 1'b1;
      end
    end
    // winner payload, qualified by found
    if (ctl.step && take) begin
      best_r.idx <= step_r;
      best_r.grp <= head.grp;
      best_r.hdl <= head.hdl;
      bprio_r    <= head_prio;
    end
  end

  assign best = best_r;
  assign last = (step_r == IDX_W'(SLOTS - 1));

endmodule

/* hw/rtl/group_priority_task_dispatcher.sv */
// An add that dispatches nothing returns its result from a register in the cycle after acceptance;
// any dispatch (done, or add while idle) returns it after the SCAN pass and the REMOVE state.
// Each request gets one result; busy is high through the scan and remove and blocks new requests.
// The scan length is set by the head tracker visiting one chain cell per cycle.
// Reset (synchronous, rst_n low): store empty, nothing running, priorities 0.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// group_priority_task_dispatcher
// Priority task dispatcher: queued handles per group, oldest-first on ties.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module group_priority_task_dispatcher
  import gptd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  req_t                    in_req,
  // result channel
  output logic                    out_valid,
  output res_t                    out_res,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PRIO_BITS-1:0]    cfg_data
);

  // FSM codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_REMOVE = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        running_r, running_nxt;
  logic                        dropped_r, dropped_nxt;
  logic                        out_valid_r, out_valid_nxt;
  res_t                        out_res_r, out_res_nxt;
  logic signed [PRIO_BITS-1:0] prio_r [NUM_PRIO];

  // chain wiring
  slot_t                       cell_q  [SLOTS];
  slot_t                       cell_nb [SLOTS];
  cell_op_t                    cell_op [SLOTS];
  logic [SLOTS-1:0]            cell_drop;
  logic [PEND_BITS-1:0]        cell_pend [SLOTS];
  logic [PEND_BITS-1:0]        pend_or;
  logic [SLOTS-1:0]            valid_vec;

  slot_t                       new_slot;
  scan_ctl_t                   scan_ctl;
  best_t                       best;
  logic                        scan_last;

  logic                        accept;
  logic                        is_add;
  logic                        full;
  logic [GROUP_BITS-1:0]       grp_in;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign is_add    = (in_req.cmd == CMD_ADD);
  assign full      = (cnt_r == CNT_W'(SLOTS));
  assign grp_in    = sat_group(in_req.group_id);

  assign new_slot.valid = 1'b1;
  assign new_slot.grp   = grp_in;
  assign new_slot.hdl   = in_req.task_handle;

  // --------------------------------------------------------------------------
  // Priority registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NUM_PRIO; g++) begin
        prio_r[g] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < NUM_PRIO)) begin
      prio_r[cfg_index] <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Slot chain. Valid entries sit in cells 0..cnt-1, oldest in cell 0.
  // During a scan the whole ring rotates toward cell 0, so after SLOTS
  // steps every entry is back in place. A removal shifts the cells above
  // the chosen one down by one, keeping the chain packed and age-ordered.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < SLOTS - 1; i++) begin
      cell_nb[i] = cell_q[i + 1];
    end
    // ring closes during scan; empty entry shifts in on removal
    cell_nb[SLOTS-1] = (state_r == S_SCAN) ? cell_q[0] : slot_t'('0);
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cell_op[i]   = CELL_HOLD;
      cell_drop[i] = (state_r == S_REMOVE) && best.found && (best.idx == IDX_W'(i));
      if (state_r == S_SCAN) begin
        cell_op[i] = CELL_TAKE;
      end else if ((state_r == S_REMOVE) && best.found && (IDX_W'(i) >= best.idx)) begin
        cell_op[i] = CELL_TAKE;
      end else if (accept && is_add && !full && (cnt_r == CNT_W'(i))) begin
        cell_op[i] = CELL_LOAD;
      end
    end
  end

  for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
    gptd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (cell_op[gi]),
      .nb    (cell_nb[gi]),
      .ld    (new_slot),
      .drop  (cell_drop[gi]),
      .q     (cell_q[gi]),
      .pend  (cell_pend[gi])
    );
  end

  // groups still pending, entry under removal already masked out
  always_comb begin
    pend_or = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pend_or      = pend_or | cell_pend[i];
      valid_vec[i] = cell_q[i].valid;
    end
  end

  // --------------------------------------------------------------------------
  // Head tracker: sees cell 0 each scan cycle, keeps the best so far
  // --------------------------------------------------------------------------
  gptd_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .head      (cell_q[0]),
    .head_prio (prio_r[cell_q[0].grp]),
    .best      (best),
    .last      (scan_last)
  );

  // --------------------------------------------------------------------------
  // Control FSM
  //   IDLE  : take a request; store an add; go scan if a dispatch is due,
  //           otherwise answer right away.
  //   SCAN  : SLOTS rotation steps through the head tracker.
  //   REMOVE: pull the winner out of the chain and answer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    running_nxt   = running_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    scan_ctl      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_add && !full) begin
            cnt_nxt = CNT_W'(cnt_r + 1'b1);
          end
          dropped_nxt = is_add && full;
          if (!is_add || !running_r) begin
            state_nxt      = S_SCAN;
            scan_ctl.clear = 1'b1;
          end else begin
            // add while a task runs: no dispatch
            out_valid_nxt              = 1'b1;
            out_res_nxt.grant_valid    = 1'b0;
            out_res_nxt.grant_handle   = '0;
            out_res_nxt.grant_group    = '0;
            out_res_nxt.add_dropped    = full;
            out_res_nxt.pending_groups = pend_or | (full ? '0 : group_onehot(grp_in));
            out_res_nxt.now_busy       = running_r;
          end
        end
      end
      S_SCAN: begin
        scan_ctl.step = 1'b1;
        if (scan_last) begin
          state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: begin
        state_nxt   = S_IDLE;
        running_nxt = best.found;
        if (best.found) begin
          cnt_nxt = CNT_W'(cnt_r - 1'b1);
        end
        out_valid_nxt              = 1'b1;
        out_res_nxt.grant_valid    = best.found;
        out_res_nxt.grant_handle   = best.found ? best.hdl : '0;
        out_res_nxt.grant_group    = best.found ? best.grp : '0;
        out_res_nxt.add_dropped    = dropped_r;
        out_res_nxt.pending_groups = pend_or;
        out_res_nxt.now_busy       = best.found;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dropped_r <= dropped_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `AST_HOLDS(a_cnt_matches_valid, $countones(valid_vec) == cnt_r, "fill count out of step with cells")
  `AST_HOLDS(a_cnt_range, cnt_r <= CNT_W'(SLOTS), "fill count above capacity")
  `AST_NEXT(a_remove_answers, state_r == S_REMOVE, out_valid && (state_r == S_IDLE), "remove gave no result")
  `AST_NEXT(a_scan_to_remove, (state_r == S_SCAN) && scan_last, state_r == S_REMOVE, "scan overran")
  `AST_SAME(a_grant_busy, out_valid && out_res.grant_valid, out_res.now_busy, "grant without busy")

endmodule

/* verif/tb_group_priority_task_dispatcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_group_priority_task_dispatcher
// Self-checking bench for the group priority task dispatcher. A behavioral
// copy of the slot store and age matrix predicts every result; directed
// orderings and a full-store case come first, then randomized add/done
// traffic under several group priority settings.
// ----------------------------------------------------------------------------
module tb_group_priority_task_dispatcher;
  import gptd_pkg::*;

  // Cycles without any accepted request, result or register write.
  localparam int WATCHDOG_LIMIT = 1000;
  // A dispatch runs through scan and remove; give a little extra after that.
  localparam int SETTLE_CYCLES  = SLOTS + 4;
  // priority_group_g sits at register index PRIO_REG_BASE + g.
  localparam int PRIO_REG_BASE  = 0;
  localparam int MAX_GAP        = 19;

  typedef enum int {PRIO_TIED, PRIO_SPREAD, PRIO_ALL_MAX, PRIO_ALL_MIN} prio_style_t;

  // DUT signals, all inputs known from time zero
  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    start     = 1'b0;
  logic                    busy;
  req_t                    in_req    = '0;
  logic                    out_valid;
  res_t                    out_res;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [PRIO_BITS-1:0]    cfg_data  = '0;

  group_priority_task_dispatcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Dispatcher shadow state
  // --------------------------------------------------------------------------
  logic                        pend_valid  [SLOTS];
  logic [GROUP_BITS-1:0]       pend_group  [SLOTS];
  logic [HANDLE_BITS-1:0]      pend_handle [SLOTS];
  // older_mask[i][j] set: slot i holds an older entry than slot j
  logic [SLOTS-1:0]            older_mask  [SLOTS];
  logic                        task_running;
  logic signed [PRIO_BITS-1:0] group_prio  [GROUPS];

  // expected results, oldest first
  res_t dispatch_outcomes[$];

  int  n_requests = 0;
  int  n_grants   = 0;
  int  n_drops    = 0;
  int  n_results  = 0;
  int  n_fail     = 0;
  bit  burst_mode = 1'b0;

  task automatic clear_shadow();
    for (int i = 0; i < SLOTS; i++) begin
      pend_valid[i]  = 1'b0;
      pend_group[i]  = '0;
      pend_handle[i] = '0;
      older_mask[i]  = '0;
    end
    for (int g = 0; g < GROUPS; g++)
      group_prio[g] = '0;
    task_running = 1'b0;
  endtask

  // Highest group priority wins; on a tie the older slot wins.
  function automatic int best_pending_slot();
    int win;
    win = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (pend_valid[i]) begin
        if (win < 0)
          win = i;
        else if (group_prio[pend_group[i]] > group_prio[pend_group[win]] ||
                 (group_prio[pend_group[i]] == group_prio[pend_group[win]] &&
                  older_mask[i][win]))
          win = i;
      end
    end
    return win;
  endfunction

  // Removes the winner from the store (its data stays readable) and
  // updates the running flag. Returns -1 when nothing is pending.
  function automatic int take_best_pending();
    int win;
    win = best_pending_slot();
    if (win < 0) begin
      task_running = 1'b0;
    end else begin
      pend_valid[win] = 1'b0;
      older_mask[win] = '0;
      for (int j = 0; j < SLOTS; j++)
        older_mask[j][win] = 1'b0;
      task_running = 1'b1;
    end
    return win;
  endfunction

  function automatic res_t predict_dispatch(input req_t req);
    res_t                  r;
    int                    slot;
    int                    win;
    logic [GROUP_BITS-1:0] grp;
    r    = '0;
    win  = -1;
    slot = -1;
    grp  = (int'(req.group_id) >= GROUPS) ? GROUP_BITS'(GROUPS - 1) : req.group_id;
    if (req.cmd == CMD_ADD) begin
      // lowest free slot takes the new task
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!pend_valid[i])
          slot = i;
      if (slot < 0) begin
        r.add_dropped = 1'b1;
      end else begin
        for (int j = 0; j < SLOTS; j++)
          if (pend_valid[j])
            older_mask[j][slot] = 1'b1;
        older_mask[slot]  = '0;
        pend_valid[slot]  = 1'b1;
        pend_group[slot]  = grp;
        pend_handle[slot] = req.task_handle;
      end
      if (!task_running)
        win = take_best_pending();
    end else begin
      // group and handle of a done are don't-care
      win = take_best_pending();
    end
    if (win >= 0) begin
      r.grant_valid  = 1'b1;
      r.grant_handle = pend_handle[win];
      r.grant_group  = pend_group[win];
    end
    for (int i = 0; i < SLOTS; i++)
      if (pend_valid[i])
        r.pending_groups[pend_group[i]] = 1'b1;
    r.now_busy = task_running;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Random gap before each request, none in burst stretches. start stays
  // high across back-to-back requests; the request is taken at the first
  // edge with busy low, and the expectation is queued at that edge.
  task automatic send_request(input logic cmd, input logic [GROUP_BITS-1:0] grp,
                              input logic [HANDLE_BITS-1:0] hdl);
    req_t req;
    res_t want;
    int   gap;
    req.cmd         = cmd;
    req.group_id    = grp;
    req.task_handle = hdl;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    want = predict_dispatch(req);
    dispatch_outcomes.push_back(want);
    n_requests++;
    if (want.grant_valid) n_grants++;
    if (want.add_dropped) n_drops++;
  endtask

  // Drain every outstanding result, then let the scan pipeline go quiet.
  task automatic settle();
    start <= 1'b0;
    while (dispatch_outcomes.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all group priorities, one register per cycle; only called idle.
  task automatic write_priorities(input logic [GROUPS*PRIO_BITS-1:0] prios);
    for (int g = 0; g < GROUPS; g++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(PRIO_REG_BASE + g);
      cfg_data  <= prios[g*PRIO_BITS +: PRIO_BITS];
      @(posedge clk);
      group_prio[g] = prios[g*PRIO_BITS +: PRIO_BITS];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [GROUPS*PRIO_BITS-1:0] draw_priorities(input prio_style_t style);
    logic [GROUPS*PRIO_BITS-1:0] v;
    logic [PRIO_BITS-1:0]        pick;
    for (int g = 0; g < GROUPS; g++) begin
      case (style)
        PRIO_TIED: begin
          // few distinct values so ties between groups are common
          case ($urandom_range(0, 4))
            0:       pick = 8'h80;
            1:       pick = 8'hFF;
            2:       pick = 8'h00;
            3:       pick = 8'h01;
            default: pick = 8'h7F;
          endcase
        end
        PRIO_SPREAD:  pick = PRIO_BITS'($urandom());
        PRIO_ALL_MAX: pick = 8'h7F;
        default:      pick = 8'h80;
      endcase
      v[g*PRIO_BITS +: PRIO_BITS] = pick;
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every strobed result pops the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (dispatch_outcomes.size() == 0) begin
        $error("result with no request outstanding: 0x%0h", out_res);
        n_fail++;
      end else begin
        want = dispatch_outcomes.pop_front();
        check_field("grant_valid",    32'(want.grant_valid),    32'(out_res.grant_valid));
        check_field("grant_handle",   32'(want.grant_handle),   32'(out_res.grant_handle));
        check_field("grant_group",    32'(want.grant_group),    32'(out_res.grant_group));
        check_field("add_dropped",    32'(want.add_dropped),    32'(out_res.add_dropped));
        check_field("pending_groups", 32'(want.pending_groups),
                    32'(out_res.pending_groups));
        check_field("now_busy",       32'(want.now_busy),       32'(out_res.now_busy));
      end
    end
  end

  // Watchdog: any handshake, result or register write counts as progress.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Priority order across groups at both extremes, oldest-first on a tie,
  // drain to idle, then done while idle with all done fields set.
  task automatic test_dispatch_order();
    settle();
    // group 7 .. 0: 127, 7, 6, 5, 1, 0, -1, -128
    write_priorities({8'h7F, 8'h07, 8'h06, 8'h05, 8'h01, 8'h00, 8'hFF, 8'h80});
    send_request(CMD_ADD,  3'd0, 16'h0000);  // idle: granted on the spot
    send_request(CMD_ADD,  3'd0, 16'hA5A5);
    send_request(CMD_ADD,  3'd3, 16'h1234);
    send_request(CMD_ADD,  3'd3, 16'h4321);  // same group, younger
    send_request(CMD_ADD,  3'd7, 16'hFFFF);
    send_request(CMD_ADD,  3'd1, 16'h5A5A);
    send_request(CMD_DONE, 3'd0, 16'h0000);  // group 7 first
    send_request(CMD_DONE, 3'd0, 16'h0000);  // older group 3 entry
    send_request(CMD_DONE, 3'd0, 16'h0000);
    send_request(CMD_DONE, 3'd0, 16'h0000);  // group 1 (-1) beats group 0 (-128)
    send_request(CMD_DONE, 3'd0, 16'h0000);
    send_request(CMD_DONE, 3'd0, 16'h0000);  // store empty: busy clears
    send_request(CMD_DONE, 3'd7, 16'hFFFF);  // done while idle
  endtask

  // Fill all slots behind a running task, then one more add is dropped.
  task automatic test_store_full();
    settle();
    write_priorities('0);
    send_request(CMD_ADD, 3'd2, 16'h0F0F);
    for (int i = 0; i < SLOTS; i++)
      send_request(CMD_ADD, GROUP_BITS'(i), HANDLE_BITS'(16'h1000 + i));
    send_request(CMD_ADD, 3'd6, 16'hDEAD);   // dropped, store full
    send_request(CMD_DONE, 3'd0, 16'h0000);
  endtask

  // Random add/done mix; add_pct steers the store toward full or empty.
  task automatic test_random_mix(input int count, input prio_style_t style,
                                 input int add_pct);
    logic cmd;
    settle();
    write_priorities(draw_priorities(style));
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 29) == 0)
        burst_mode = !burst_mode;
      cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_DONE;
      send_request(cmd, GROUP_BITS'($urandom()), HANDLE_BITS'($urandom()));
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    clear_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_dispatch_order();
    test_store_full();
    test_random_mix(115, PRIO_TIED,    60);
    test_random_mix(115, PRIO_SPREAD,  75);
    test_random_mix(115, PRIO_ALL_MAX, 45);
    test_random_mix(115, PRIO_ALL_MIN, 85);
    test_random_mix(115, PRIO_TIED,    35);
    test_random_mix(115, PRIO_SPREAD,  55);

    settle();
    $display("Covered %0d requests: %0d dispatches, %0d dropped adds, %0d results checked",
             n_requests, n_grants, n_drops, n_results);
    $display("Priority sets: tied, spread, all max, all min; store cycled empty to full");
    if (n_fail == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
